/* src/lct_pkg.sv */
// shared constants, types and helpers for the lfu cache table
package lct_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 16;
  localparam int unsigned CAP_W             = 5;
  localparam int unsigned KEY_W             = 32;
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned COUNT_W           = 32;
  localparam int unsigned ENTRY_W           = KEY_W + VALUE_W + COUNT_W;

  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
  localparam logic [VALUE_W-1:0] MISS_VALUE  = '1;
  localparam logic [VALUE_W-1:0] PUT_VALUE   = '0;
  localparam logic [COUNT_W-1:0] FIRST_COUNT = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef struct packed {
    logic hit;
    logic free;
    logic victim;
  } lct_scan_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

/* src/lct_ram.sv */
// generic single write port ram with registered read
module lct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/lct_scan.sv */
// scan unit: key match, first free slot, fill count and lfu victim search
module lct_scan import lct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IW            = 4,
  parameter int unsigned RW            = 4,
  parameter int unsigned UW            = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               beat_i,
  input  logic [IW-1:0]      idx_i,
  input  logic               slot_valid_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [ENTRY_W-1:0] entry_i,
  input  logic [RW-1:0]      rank_i,
  output lct_scan_t          flags_o,
  output logic [IW-1:0]      hit_idx_o,
  output logic [ENTRY_W-1:0] hit_entry_o,
  output logic [RW-1:0]      hit_rank_o,
  output logic [IW-1:0]      free_idx_o,
  output logic [IW-1:0]      victim_idx_o,
  output logic [RW-1:0]      victim_rank_o,
  output logic [UW-1:0]      used_o
);

  lct_scan_t          flags_q, flags_d;
  logic [UW-1:0]      used_q, used_d;
  logic [IW-1:0]      hit_idx_q, free_idx_q, victim_idx_q;
  logic [ENTRY_W-1:0] hit_entry_q;
  logic [RW-1:0]      hit_rank_q, victim_rank_q;
  logic [COUNT_W-1:0] victim_count_q;
  logic [KEY_W-1:0]   ent_key;
  logic [COUNT_W-1:0] ent_count;
  logic               take_hit, take_free, take_victim;

  assign ent_key   = entry_i[ENTRY_W-1 -: KEY_W];
  assign ent_count = entry_i[COUNT_W-1:0];

  always_comb begin
    take_hit    = beat_i && slot_valid_i && (ent_key == key_i);
    take_free   = beat_i && !slot_valid_i && !flags_q.free;
    take_victim = beat_i && slot_valid_i &&
                  (!flags_q.victim || (ent_count < victim_count_q) ||
                   ((ent_count == victim_count_q) && (rank_i > victim_rank_q)));
    flags_d = flags_q;
    used_d  = used_q;
    if (clear_i) begin
      flags_d = '0;
      used_d  = '0;
    end else begin
      if (take_hit)    flags_d.hit    = 1'b1;
      if (take_free)   flags_d.free   = 1'b1;
      if (take_victim) flags_d.victim = 1'b1;
      if (beat_i && slot_valid_i) used_d = used_q + UW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      used_q  <= '0;
    end else begin
      flags_q <= flags_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q   <= idx_i;
      hit_entry_q <= entry_i;
      hit_rank_q  <= rank_i;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
    if (take_victim) begin
      victim_idx_q   <= idx_i;
      victim_rank_q  <= rank_i;
      victim_count_q <= ent_count;
    end
  end

  assign flags_o       = flags_q;
  assign hit_idx_o     = hit_idx_q;
  assign hit_entry_o   = hit_entry_q;
  assign hit_rank_o    = hit_rank_q;
  assign free_idx_o    = free_idx_q;
  assign victim_idx_o  = victim_idx_q;
  assign victim_rank_o = victim_rank_q;
  assign used_o        = used_q;

endmodule

/* src/lfu_cache_table_top.sv */
// top level of the lfu cache table with lru tie-break
//
// Key/value cache. An input transfer carries action (0 get, 1 put), key and
// value; every input transfer yields exactly one output transfer with found
// and read_value, in order. The capacity register is written over the cfg
// channel, which is always ready; write it only while the block is idle.
// An item runs through a sequencer: one scan pass over all TABLE_ENTRIES
// slots reads the entry and rank memories to find the key, the first free
// slot and the least frequently used victim, then a decision state writes
// the entry where the item needs it, then a second pass rewrites the recency
// ranks; a get miss or a dropped put skips the rank pass. in_ready_o is high
// only while idle, so a new item is accepted only once the last one is
// through its passes. Both passes are set by the single read port of each
// memory, one slot per cycle. A new item may be accepted while the last
// result still waits. If the receiver stalls, the result is held and a
// finished item waits.
// Reset clears all valid bits and sets capacity to 16; no clearing pass.
module lfu_cache_table_top import lct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [VALUE_W-1:0] read_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i
);

  localparam int unsigned IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned RW   = IW;
  localparam int unsigned UW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMPW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [IW-1:0]   LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [CMPW-1:0] MAX_CAP  = CMPW'(TABLE_ENTRIES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SFLUSH = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RANK   = 3'd4;
  localparam logic [2:0] S_RFLUSH = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [IW-1:0]            addr_q, addr_d;
  logic                     rd_vld_q;
  logic [IW-1:0]            rd_idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CAP_W-1:0]         cap_q;
  logic                     out_valid_q;
  logic                     found_q;
  logic [VALUE_W-1:0]       read_value_q;

  logic                     is_put_q;
  logic [KEY_W-1:0]         key_q;
  logic [VALUE_W-1:0]       value_q;
  logic [IW-1:0]            tgt_q, tgt_d;
  logic [RW-1:0]            ref_rank_q, ref_rank_d;
  logic                     all_q, all_d;
  logic                     res_found_q, res_found_d;
  logic [VALUE_W-1:0]       res_value_q, res_value_d;

  logic                     in_xfer;
  logic                     out_load;
  logic                     scan_beat, rank_beat;
  logic [CMPW-1:0]          cap_eff;
  logic                     has_room;

  logic                     ent_we;
  logic [IW-1:0]            ent_waddr;
  logic [ENTRY_W-1:0]       ent_wdata;
  logic [ENTRY_W-1:0]       ent_rdata;
  logic                     rank_we;
  logic [RW-1:0]            rank_wdata;
  logic [RW-1:0]            rank_rdata;
  logic                     rk_tgt, rk_inc;

  lct_scan_t                scan_flags;
  logic [IW-1:0]            hit_idx, free_idx, victim_idx;
  logic [ENTRY_W-1:0]       hit_entry;
  logic [RW-1:0]            hit_rank, victim_rank;
  logic [UW-1:0]            used;
  logic [VALUE_W-1:0]       hit_data;
  logic [COUNT_W-1:0]       hit_count;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign scan_beat   = rd_vld_q && ((state_q == S_SCAN) || (state_q == S_SFLUSH));
  assign rank_beat   = rd_vld_q && ((state_q == S_RANK) || (state_q == S_RFLUSH));

  assign hit_data  = hit_entry[COUNT_W +: VALUE_W];
  assign hit_count = hit_entry[COUNT_W-1:0];
  assign cap_eff   = (CMPW'(cap_q) > MAX_CAP) ? MAX_CAP : CMPW'(cap_q);
  assign has_room  = (CMPW'(used) < cap_eff) && scan_flags.free;

  lct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (addr_q),
    .rdata_o (ent_rdata)
  );

  lct_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (addr_q),
    .rdata_o (rank_rdata)
  );

  lct_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IW            (IW),
    .RW            (RW),
    .UW            (UW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (in_xfer),
    .beat_i        (scan_beat),
    .idx_i         (rd_idx_q),
    .slot_valid_i  (valid_q[rd_idx_q]),
    .key_i         (key_q),
    .entry_i       (ent_rdata),
    .rank_i        (rank_rdata),
    .flags_o       (scan_flags),
    .hit_idx_o     (hit_idx),
    .hit_entry_o   (hit_entry),
    .hit_rank_o    (hit_rank),
    .free_idx_o    (free_idx),
    .victim_idx_o  (victim_idx),
    .victim_rank_o (victim_rank),
    .used_o        (used)
  );

  // rank pass: target goes to zero, younger valid entries age by one (all valid entries on an insert into a free slot)
  always_comb begin
    rk_tgt     = (rd_idx_q == tgt_q);
    rk_inc     = valid_q[rd_idx_q] && !rk_tgt && (all_q || (rank_rdata < ref_rank_q));
    rank_we    = rank_beat && (rk_tgt || rk_inc);
    rank_wdata = rk_tgt ? '0 : rank_rdata + RW'(1);
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    valid_d     = valid_q;
    tgt_d       = tgt_q;
    ref_rank_d  = ref_rank_q;
    all_d       = all_q;
    res_found_d = res_found_q;
    res_value_d = res_value_q;
    ent_we      = 1'b0;
    ent_waddr   = hit_idx;
    ent_wdata   = {key_q, value_q, FIRST_COUNT};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
          addr_d  = '0;
        end
      end
      S_SCAN, S_RANK: begin
        if (addr_q == LAST_IDX) begin
          state_d = (state_q == S_SCAN) ? S_SFLUSH : S_RFLUSH;
        end else begin
          addr_d = addr_q + IW'(1);
        end
      end
      S_SFLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        addr_d      = '0;
        res_found_d = scan_flags.hit;
        res_value_d = PUT_VALUE;
        all_d       = 1'b0;
        state_d     = S_DONE;
        if (scan_flags.hit) begin
          if (!is_put_q) begin
            res_value_d = hit_data;
          end
          ent_we     = 1'b1;
          ent_waddr  = hit_idx;
          ent_wdata  = {key_q, (is_put_q ? value_q : hit_data), sat_inc(hit_count)};
          tgt_d      = hit_idx;
          ref_rank_d = hit_rank;
          state_d    = S_RANK;
        end else if (!is_put_q) begin
          res_value_d = MISS_VALUE;
        end else if (cap_eff == '0) begin
          state_d = S_DONE;
        end else if (has_room) begin
          ent_we           = 1'b1;
          ent_waddr        = free_idx;
          valid_d[free_idx] = 1'b1;
          tgt_d            = free_idx;
          all_d            = 1'b1;
          state_d          = S_RANK;
        end else if (scan_flags.victim) begin
          ent_we     = 1'b1;
          ent_waddr  = victim_idx;
          tgt_d      = victim_idx;
          ref_rank_d = victim_rank;
          state_d    = S_RANK;
        end
      end
      S_RFLUSH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      rd_vld_q <= (state_q == S_SCAN) || (state_q == S_RANK);
      valid_q  <= valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= addr_q;
    tgt_q       <= tgt_d;
    ref_rank_q  <= ref_rank_d;
    all_q       <= all_d;
    res_found_q <= res_found_d;
    res_value_q <= res_value_d;
    if (in_xfer) begin
      is_put_q <= action_i;
      key_q    <= key_i;
      value_q  <= value_i;
    end
    if (out_load) begin
      found_q      <= res_found_q;
      read_value_q <= res_value_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  // a stalled finished item waits and does not overwrite the pending result
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while receiver stalls");

  // a get miss leaves the table untouched
  a_get_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && !scan_flags.hit && !is_put_q) |-> (!ent_we && valid_d == valid_q))
    else $error("get miss modified the table");

  // rank memory is only written during the rank pass
  a_rank_we_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_we |-> (state_q == S_RANK || state_q == S_RFLUSH))
    else $error("rank write outside rank pass");

  // an accepted item drops ready on the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready high right after input transfer");

endmodule

/* tb/lct_tb_pkg.sv */
// action codes shared by the lfu cache table testbench files
package lct_tb_pkg;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } lct_action_e;

endpackage

/* tb/lct_checker.sv */
// lfu cache table checker: predicts each answer and compares it with the output transfer
module lct_checker import lct_pkg::*, lct_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               action_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               found_i,
  input  logic [VALUE_W-1:0] read_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CAP_W-1:0]   cfg_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  localparam int SLOTS = DEF_TABLE_ENTRIES;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
  } answer_t;

  logic [CAP_W-1:0]   cap_q;
  bit                 slot_live [SLOTS];
  logic [KEY_W-1:0]   slot_key  [SLOTS];
  logic [VALUE_W-1:0] slot_val  [SLOTS];
  logic [COUNT_W-1:0] slot_uses [SLOTS];
  int unsigned        slot_age  [SLOTS];
  answer_t            answer_q  [$];

  function automatic answer_t serve_item(input logic is_put, input logic [KEY_W-1:0] k,
                                         input logic [VALUE_W-1:0] v);
    answer_t     ans;
    int          hit;
    int          free_idx;
    int          victim;
    int          target;
    int unsigned used;
    int unsigned lim;
    int unsigned age;
    hit      = -1;
    free_idx = -1;
    victim   = -1;
    used     = 0;
    lim      = (cap_q > SLOTS) ? SLOTS : cap_q;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) begin
        used++;
        if (slot_key[i] == k) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end

    if (hit >= 0) begin
      if (slot_uses[hit] != COUNT_MAX) slot_uses[hit] = slot_uses[hit] + 1'b1;
      age = slot_age[hit];
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && i != hit && slot_age[i] < age) slot_age[i]++;
      slot_age[hit] = 0;
      ans.found = 1'b1;
      ans.read_value = is_put ? PUT_VALUE : slot_val[hit];
      if (is_put) slot_val[hit] = v;
      return ans;
    end

    ans.found = 1'b0;
    ans.read_value = is_put ? PUT_VALUE : MISS_VALUE;
    if (!is_put || lim == 0) return ans;

    if (used < lim && free_idx >= 0) begin
      target = free_idx;
    end else begin
      // fewest uses first, oldest touch breaks ties
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_live[i]) continue;
        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))
          victim = i;
      end
      if (victim < 0) return ans;
      age = slot_age[victim];
      slot_live[victim] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && slot_age[i] > age) slot_age[i]--;
      target = victim;
    end

    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i]) slot_age[i]++;
    slot_live[target] = 1'b1;
    slot_key[target]  = k;
    slot_val[target]  = v;
    slot_uses[target] = FIRST_COUNT;
    slot_age[target]  = 0;
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      cap_q = CAP_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      answer_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: output transfer with nothing expected: found=%0b read_value=%0d",
                   $time, found_i, $signed(read_value_i));
        end else begin
          want = answer_q.pop_front();
          if (found_i !== want.found || read_value_i !== want.read_value) begin
            fail_cnt_o++;
            $display("%0t: mismatch: expected found=%0b read_value=%0d,",
                     $time, want.found, $signed(want.read_value),
                     " got found=%0b read_value=%0d", found_i, $signed(read_value_i));
          end
        end
      end
      if (in_valid_i && in_ready_i)
        answer_q.push_back(serve_item(action_i == ACT_PUT, key_i, value_i));
      if (cfg_valid_i && cfg_ready_i) cap_q = cfg_data_i;
      pending_o = answer_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top for the lfu cache table: stimulus, flow control and verdict
module tb_top import lct_pkg::*, lct_tb_pkg::*;;

  localparam int LIMIT      = 1000000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 155;
  localparam int POOL       = 24;
  localparam int SETTLE     = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic [KEY_W-1:0]   key_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               found_o;
  logic [VALUE_W-1:0] read_value_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CAP_W-1:0]   cfg_data_i;

  int                 fail_cnt;
  int                 pending;
  int                 cycle_cnt;
  int                 burst_left;
  bit                 gaps_on;
  int                 stall_mode;
  int                 mode_left;
  logic [KEY_W-1:0]   key_pool [POOL];
  logic [CAP_W-1:0]   phase_cap [PHASES] = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd16,
                                              5'd2, 5'd31, 5'd3, 5'd8, 5'd16};

  lfu_cache_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  lct_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_i      (found_o),
    .read_value_i (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall pattern
  initial begin
    stall_mode = 0;
    mode_left  = 0;
  end

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= $urandom_range(0, 1);
      end
      2: begin
        out_ready_i <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready_i <= (mode_left % 5 == 0);
      end
    endcase
  end

  task automatic send_item(input lct_action_e act, input logic [KEY_W-1:0] k,
                           input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 45) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int               psize;
    int               pick;
    int unsigned      eff_cap;
    logic [KEY_W-1:0] k;
    logic [VALUE_W-1:0] v;
    lct_action_e      act;

    in_valid_i  = 1'b0;
    action_i    = ACT_GET;
    key_i       = '0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, update on put hit, eviction and tie-break
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    // capacity below the number of entries
    write_capacity(5'd2);
    send_item(ACT_PUT, 32'h1234_5678, 32'h0000_0005);
    send_item(ACT_PUT, 32'h9ABC_DEF0, 32'h0000_0006);
    send_item(ACT_GET, 32'h9ABC_DEF0, 32'h0000_0000);
    send_item(ACT_PUT, 32'h5555_AAAA, 32'h0000_0007);
    // equal counts: the older entry goes
    write_capacity(5'd3);
    send_item(ACT_PUT, 32'hAAAA_5555, 32'h0000_0008);
    send_item(ACT_PUT, 32'h0F0F_F0F0, 32'h0000_0009);
    send_item(ACT_GET, 32'h5555_AAAA, 32'h0000_0000);
    // capacity zero drops put misses, serves hits
    write_capacity(5'd0);
    send_item(ACT_PUT, 32'h0BAD_F00D, 32'h0000_000A);
    send_item(ACT_PUT, 32'hAAAA_5555, 32'h8000_0000);
    send_item(ACT_GET, 32'h0BAD_F00D, 32'h0000_0000);
    write_capacity(5'd1);
    send_item(ACT_PUT, 32'hCAFE_0001, 32'h0000_000B);
    send_item(ACT_GET, 32'hCAFE_0001, 32'h0000_0000);

    // random phases over a range of capacities
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      for (int i = 0; i < 4; i++) key_pool[$urandom_range(2, POOL - 1)] = $urandom;
      eff_cap = (phase_cap[p] > DEF_TABLE_ENTRIES) ? DEF_TABLE_ENTRIES : phase_cap[p];
      psize   = (eff_cap + 3 < 4) ? 4 : eff_cap + 3;
      gaps_on = (p != 4);
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) k = key_pool[$urandom_range(0, psize - 1)];
        else if (pick < 95) k = $urandom;
        else k = key_pool[$urandom_range(0, 1)];
        pick = $urandom_range(0, 19);
        if (pick == 0) v = 32'h8000_0000;
        else if (pick == 1) v = 32'h7FFF_FFFF;
        else v = $urandom;
        act = ($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET;
        send_item(act, k, v);
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
